// ===== rtl/uid_range_discovery_manager_core_defines.svh =====
// assertion macros shared by the checker
`ifndef UID_RANGE_DISCOVERY_MANAGER_CORE_DEFINES_SVH
`define UID_RANGE_DISCOVERY_MANAGER_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define URDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urdm check failed");

// next-cycle implication, reset masked
`define URDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urdm check failed");

`endif

// ===== rtl/urdm_pkg.sv =====
// shared constants and codes of the uid range discovery manager
`default_nettype none
package urdm_pkg;
  localparam int UID_W       = 48;
  localparam int TRANS_W     = 32;
  localparam int FILT_W      = 8;
  localparam int TMO_W       = 16;
  localparam int MAX_LISTED  = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIST_W      = $clog2(MAX_LISTED + 1);
  localparam logic [1:0] CLEAN_LIMIT = 2'd3;
  localparam logic [UID_W-1:0] UID_TOP = {UID_W{1'b1}};
  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(1000);

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_REPLY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_HDR    = 2'd0,
    KIND_LISTED = 2'd1,
    KIND_FOUND  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  localparam logic CFG_FILTER  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/uid_range_discovery_manager_core.sv =====
// top level: uid range discovery manager with the known-uid table in a ram
//
// One item is taken when start is high and busy is low; busy stays high while the
// item is processed. Each result is shown for one cycle on out_valid and cannot be
// held off. Stop and ignored items leave busy low. A reply gives its target result
// in the cycle after it is taken, then the uid is searched for, shifted in and
// inserted into the sorted table. A probe walks the table to count uids in range,
// once more after each bound halving, then once more to list them if any are in
// range, all through the single read port of the table.
`default_nettype none
module uid_range_discovery_manager_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_action,
  input  wire logic [urdm_pkg::UID_W-1:0]   in_reply_uid,
  input  wire logic                         in_addressed_to_me,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [urdm_pkg::UID_W-1:0]        out_lower_bound,
  output logic [urdm_pkg::UID_W-1:0]        out_upper_bound,
  output logic [urdm_pkg::TRANS_W-1:0]      out_transaction,
  output logic [urdm_pkg::FILT_W-1:0]       out_filter_bits,
  output logic [urdm_pkg::UID_W-1:0]        out_uid_value,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [urdm_pkg::TMO_W-1:0]   cfg_data
);
  import urdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CNT, S_EMIT, S_SRCH, S_SHIFT, S_INS
  } state_t;

  state_t               state_r;
  logic                 active_r;
  logic [UID_W-1:0]     low_r, high_r, uid_r;
  logic [1:0]           clean_r;
  logic [TRANS_W-1:0]   trans_r;
  logic [TMO_W-1:0]     timer_r, timeout_r;
  logic [FILT_W-1:0]    filter_r;
  logic [CNT_W-1:0]     count_r, rd_i_r, sh_r, pos_r, hits_r;
  logic [LIST_W-1:0]    nlist_r, sent_r;
  logic                 rv_r;
  logic [AW-1:0]        rv_idx_r;

  logic                 out_valid_r, out_last_r;
  logic [1:0]           out_kind_r;
  logic [UID_W-1:0]     out_lo_r, out_hi_r, out_uid_r;
  logic [TRANS_W-1:0]   out_trans_r;
  logic [FILT_W-1:0]    out_filt_r;

  logic [UID_W-1:0]     mem [TABLE_DEPTH];
  logic [UID_W-1:0]     mem_rdata_r;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  logic [UID_W-1:0]     mem_wdata;
  logic                 mem_we;

  logic                 issue, scan_done, in_rng;
  logic [UID_W:0]       mid_sum;
  logic [TMO_W-1:0]     timer_dec;

  always_comb begin
    if (state_r == S_SHIFT) begin
      mem_raddr = AW'(sh_r - CNT_W'(1));
      issue     = sh_r > pos_r;
    end else begin
      mem_raddr = rd_i_r[AW-1:0];
      issue     = rd_i_r < count_r;
    end
    mem_we    = (state_r == S_SHIFT && rv_r) || state_r == S_INS;
    mem_waddr = (state_r == S_INS) ? pos_r[AW-1:0] : AW'(rv_idx_r + AW'(1));
    mem_wdata = (state_r == S_INS) ? uid_r : mem_rdata_r;
    scan_done = !issue && !rv_r;
    in_rng    = mem_rdata_r >= low_r && mem_rdata_r <= high_r;
    mid_sum   = {1'b0, low_r} + {1'b0, high_r};
    timer_dec = (timer_r != '0) ? TMO_W'(timer_r - TMO_W'(1)) : timer_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      low_r       <= '0;
      high_r      <= UID_TOP;
      clean_r     <= '0;
      trans_r     <= '0;
      timer_r     <= '0;
      count_r     <= '0;
      filter_r    <= '0;
      timeout_r   <= TMO_RESET;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_lo_r    <= '0;
      out_hi_r    <= '0;
      out_trans_r <= '0;
      out_filt_r  <= '0;
      out_uid_r   <= '0;
      rv_r        <= issue;
      rv_idx_r    <= mem_raddr;
      if (issue) begin
        rd_i_r <= CNT_W'(rd_i_r + CNT_W'(1));
        sh_r   <= CNT_W'(sh_r - CNT_W'(1));
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_FILTER) begin
          filter_r <= cfg_data[FILT_W-1:0];
        end else begin
          timeout_r <= cfg_data;
        end
      end
      case (state_r)
        S_IDLE: begin
          rv_r <= 1'b0;
          if (start) begin
            case (in_action)
              ACT_START: begin
                if (!active_r) begin
                  count_r  <= '0;
                  low_r    <= '0;
                  high_r   <= UID_TOP;
                  clean_r  <= '0;
                  active_r <= 1'b1;
                  state_r  <= S_PROBE;
                end
              end
              ACT_STOP: begin
                active_r <= 1'b0;
                if (active_r) begin
                  count_r <= '0;
                end
              end
              ACT_TICK: begin
                if (active_r) begin
                  timer_r <= timer_dec;
                  if (timer_dec == '0) begin
                    state_r <= S_PROBE;
                  end
                end
              end
              default: begin
                if (active_r && in_addressed_to_me) begin
                  clean_r     <= '0;
                  uid_r       <= in_reply_uid;
                  out_valid_r <= 1'b1;
                  out_kind_r  <= KIND_FOUND;
                  out_uid_r   <= in_reply_uid;
                  out_last_r  <= 1'b1;
                  rd_i_r      <= '0;
                  if (count_r < CNT_W'(TABLE_DEPTH)) begin
                    state_r <= S_SRCH;
                  end
                end
              end
            endcase
          end
        end
        S_PROBE: begin
          rd_i_r <= '0;
          hits_r <= '0;
          rv_r   <= 1'b0;
          state_r <= S_CNT;
          if (clean_r >= CLEAN_LIMIT) begin
            if (high_r == UID_TOP) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_DONE;
              out_last_r  <= 1'b1;
              active_r    <= 1'b0;
              count_r     <= '0;
              state_r     <= S_IDLE;
            end else begin
              low_r   <= UID_W'(high_r + UID_W'(1));
              high_r  <= UID_TOP;
              clean_r <= '0;
            end
          end
        end
        S_CNT: begin
          if (rv_r && in_rng) begin
            hits_r <= CNT_W'(hits_r + CNT_W'(1));
          end
          if (scan_done) begin
            rd_i_r <= '0;
            hits_r <= '0;
            if (hits_r > CNT_W'(MAX_LISTED)) begin
              high_r <= mid_sum[UID_W:1];
            end else begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_HDR;
              out_lo_r    <= low_r;
              out_hi_r    <= high_r;
              out_trans_r <= trans_r;
              out_filt_r  <= filter_r;
              out_last_r  <= hits_r == '0;
              trans_r     <= TRANS_W'(trans_r + TRANS_W'(1));
              timer_r     <= timeout_r;
              clean_r     <= 2'(clean_r + 2'd1);
              nlist_r     <= hits_r[LIST_W-1:0];
              sent_r      <= '0;
              state_r     <= (hits_r == '0) ? S_IDLE : S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (rv_r && in_rng) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_LISTED;
            out_uid_r   <= mem_rdata_r;
            out_last_r  <= LIST_W'(sent_r + LIST_W'(1)) == nlist_r;
            sent_r      <= LIST_W'(sent_r + LIST_W'(1));
          end
          if (scan_done) begin
            state_r <= S_IDLE;
          end
        end
        S_SRCH: begin
          if (rv_r && mem_rdata_r >= uid_r) begin
            rv_r <= 1'b0;
            if (mem_rdata_r == uid_r) begin
              state_r <= S_IDLE;
            end else begin
              pos_r   <= CNT_W'(rv_idx_r);
              sh_r    <= count_r;
              state_r <= S_SHIFT;
            end
          end else if (scan_done) begin
            pos_r   <= count_r;
            state_r <= S_INS;
          end
        end
        S_SHIFT: begin
          if (scan_done) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          count_r <= CNT_W'(count_r + CNT_W'(1));
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_lower_bound = out_lo_r;
  assign out_upper_bound = out_hi_r;
  assign out_transaction = out_trans_r;
  assign out_filter_bits = out_filt_r;
  assign out_uid_value   = out_uid_r;
  assign out_last        = out_last_r;
endmodule
`default_nettype wire

// ===== rtl/urdm_checker.sv =====
// port-level checks of the discovery manager and their bind
`default_nettype none
`include "uid_range_discovery_manager_core_defines.svh"
module urdm_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 in_action,
  input wire logic [urdm_pkg::UID_W-1:0] in_reply_uid,
  input wire logic                       out_valid,
  input wire logic [1:0]                 out_kind,
  input wire logic [urdm_pkg::UID_W-1:0] out_lower_bound,
  input wire logic [urdm_pkg::UID_W-1:0] out_uid_value,
  input wire logic                       out_last
);
  import urdm_pkg::*;

  logic found_v, alone_v, took_v, stop_v;

  assign found_v = out_valid && out_kind == KIND_FOUND;
  assign alone_v = found_v || (out_valid && out_kind == KIND_DONE);
  assign took_v  = start && !busy;
  assign stop_v  = took_v && in_action == ACT_STOP;

  // found and finish items are always alone
  `URDM_ASSERT_NOW(a_single_last, alone_v, out_last)
  // target report follows the accepted reply directly
  `URDM_ASSERT_NOW(a_found_src, found_v, $past(took_v) && $past(in_action) == ACT_REPLY)
  `URDM_ASSERT_NOW(a_found_uid, found_v, out_uid_value == $past(in_reply_uid))
  // stop never occupies the block
  `URDM_ASSERT_NEXT(a_stop_fast, stop_v, !busy)
  `URDM_ASSERT_NOW(a_bound_zero, out_valid && out_kind != KIND_HDR, out_lower_bound == '0)
endmodule

bind uid_range_discovery_manager_core urdm_checker u_urdm_checker (.*);
`default_nettype wire
